/* design/rtmc_pkg.sv */
package rtmc_pkg;

  // Cipher constants
  localparam logic [15:0] T_TAP_MASK = 16'hc533;
  localparam logic [7:0]  INIT_B     = 8'h4c;
  localparam logic [7:0]  INIT_L_ADD = 8'hec;
  localparam logic [7:0]  INIT_R_ADD = 8'h21;
  localparam logic [15:0] INIT_T     = 16'he012;
  localparam int          OUT_BIT    = 2;

  // Step counts per phase
  localparam int CC_STEPS  = 64;
  localparam int NR_STEPS  = 32;
  localparam int MIX_STEPS = 32;
  localparam int OUT_STEPS = 32;
  localparam int IN_STEPS  = CC_STEPS + NR_STEPS;
  localparam int OUT_START = IN_STEPS + MIX_STEPS;
  localparam int N_STEPS   = OUT_START + OUT_STEPS;

  typedef struct packed {
    logic [7:0]  l;
    logic [7:0]  r;
    logic [7:0]  b;
    logic [15:0] t;
  } cipher_state_t;

  // Key byte select table, indexed by the right byte
  localparam logic [2:0] SEL_TABLE [256] = '{
    3'd0,3'd3,3'd2,3'd1,3'd2,3'd3,3'd0,3'd1,3'd4,3'd7,3'd7,3'd4,3'd6,3'd7,3'd5,3'd4,
    3'd1,3'd2,3'd3,3'd0,3'd2,3'd3,3'd0,3'd1,3'd5,3'd6,3'd6,3'd5,3'd6,3'd7,3'd5,3'd4,
    3'd6,3'd5,3'd4,3'd7,3'd4,3'd5,3'd6,3'd7,3'd6,3'd5,3'd5,3'd6,3'd4,3'd5,3'd7,3'd6,
    3'd7,3'd4,3'd5,3'd6,3'd4,3'd5,3'd6,3'd7,3'd7,3'd4,3'd4,3'd7,3'd4,3'd5,3'd7,3'd6,
    3'd6,3'd5,3'd4,3'd7,3'd4,3'd5,3'd6,3'd7,3'd2,3'd1,3'd1,3'd2,3'd0,3'd1,3'd3,3'd2,
    3'd3,3'd0,3'd1,3'd2,3'd0,3'd1,3'd2,3'd3,3'd7,3'd4,3'd4,3'd7,3'd4,3'd5,3'd7,3'd6,
    3'd0,3'd3,3'd2,3'd1,3'd2,3'd3,3'd0,3'd1,3'd0,3'd3,3'd3,3'd0,3'd2,3'd3,3'd1,3'd0,
    3'd5,3'd6,3'd7,3'd4,3'd6,3'd7,3'd4,3'd5,3'd5,3'd6,3'd6,3'd5,3'd6,3'd7,3'd5,3'd4,
    3'd2,3'd1,3'd0,3'd3,3'd0,3'd1,3'd2,3'd3,3'd6,3'd5,3'd5,3'd6,3'd4,3'd5,3'd7,3'd6,
    3'd3,3'd0,3'd1,3'd2,3'd0,3'd1,3'd2,3'd3,3'd7,3'd4,3'd4,3'd7,3'd4,3'd5,3'd7,3'd6,
    3'd2,3'd1,3'd0,3'd3,3'd0,3'd1,3'd2,3'd3,3'd2,3'd1,3'd1,3'd2,3'd0,3'd1,3'd3,3'd2,
    3'd3,3'd0,3'd1,3'd2,3'd0,3'd1,3'd2,3'd3,3'd3,3'd0,3'd0,3'd3,3'd0,3'd1,3'd3,3'd2,
    3'd4,3'd7,3'd6,3'd5,3'd6,3'd7,3'd4,3'd5,3'd0,3'd3,3'd3,3'd0,3'd2,3'd3,3'd1,3'd0,
    3'd1,3'd2,3'd3,3'd0,3'd2,3'd3,3'd0,3'd1,3'd5,3'd6,3'd6,3'd5,3'd6,3'd7,3'd5,3'd4,
    3'd4,3'd7,3'd6,3'd5,3'd6,3'd7,3'd4,3'd5,3'd4,3'd7,3'd7,3'd4,3'd6,3'd7,3'd5,3'd4,
    3'd1,3'd2,3'd3,3'd0,3'd2,3'd3,3'd0,3'd1,3'd1,3'd2,3'd2,3'd1,3'd2,3'd3,3'd1,3'd0
  };

  // Starting state from key byte 0
  function automatic cipher_state_t cipher_init(logic [7:0] key0);
    logic [7:0]    k0;
    cipher_state_t s;
    k0  = key0 ^ INIT_B;
    s.l = k0 + INIT_L_ADD;
    s.r = k0 + INIT_R_ADD;
    s.b = INIT_B;
    s.t = INIT_T;
    return s;
  endfunction

  // One cipher step with input bit y
  function automatic cipher_state_t cipher_step(cipher_state_t s, logic y,
                                                logic [63:0] key);
    logic [15:0]   tt;
    logic          fb_t;
    logic          fb_b;
    logic [2:0]    lut;
    logic [2:0]    sel;
    logic [7:0]    new_b;
    logic [7:0]    new_r;
    cipher_state_t n;
    tt = s.t & T_TAP_MASK;
    tt = tt ^ (tt >> 1);
    tt = tt ^ (tt >> 4);
    tt = tt ^ (tt >> 10);
    tt = tt ^ (tt >> 8);
    fb_t  = tt[0] ^ s.r[7] ^ s.r[3];
    fb_b  = s.b[0] ^ s.b[6] ^ s.b[5] ^ s.b[4] ^ s.r[0];
    new_b = {fb_b, s.b[7:1]};
    lut   = SEL_TABLE[s.r];
    sel   = {lut[2], lut[1] ^ tt[0] ^ y, lut[0] ^ tt[0]};
    new_r = (key[{sel, 3'b000} +: 8] ^ new_b) + s.l;
    n.t   = {fb_t, s.t[15:1]};
    n.b   = new_b;
    n.r   = new_r;
    n.l   = new_r + s.r;
    return n;
  endfunction

endpackage

/* design/rfid_tag_mac_cipher.sv */
// Channel | valid     | stall      | payload
// --------+-----------+------------+-------------------------------------
// in      | in_valid  | in_stall   | card_challenge[63:0], reader_nonce[31:0]
// out     | out_valid | out_stall  | tag_mac[31:0]
// cfg     | cfg_we    | -          | diversified_key[63:0]
//
// One word accepted per cycle while in_stall is low; one load stage plus one
// register stage per cipher step, 160 steps in all.
// rst clears all stage valid bits; the key register resets to zero.
// The whole pipe holds while the output word waits under out_stall; in_stall
// follows from that, so no word is dropped or repeated.
module rfid_tag_mac_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] diversified_key,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] card_challenge,
  input  logic [31:0] reader_nonce,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] tag_mac
);

  localparam int NS = rtmc_pkg::N_STEPS;
  localparam int NI = rtmc_pkg::IN_STEPS;
  localparam int OS = rtmc_pkg::OUT_START;

  logic [63:0]             key;
  logic                    vld  [0:NS];
  rtmc_pkg::cipher_state_t st   [0:NS];
  logic [NI-1:0]           din  [0:NI-1];
  logic [31:0]             mac  [OS+1:NS];
  logic                    adv;

  // Key register
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      key <= diversified_key;
    end
  end

  // Global advance: hold everything while the output word is stalled
  assign adv      = !(vld[NS] && out_stall);
  assign in_stall = vld[NS] && out_stall;

  // Load stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0]  <= rtmc_pkg::cipher_init(key[7:0]);
      din[0] <= {reader_nonce, card_challenge};
    end
  end

  // One cipher step per stage
  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic y;

    if (s < NI) begin : g_in
      assign y = din[s][0];
    end else begin : g_zero
      assign y = 1'b0;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[s+1] <= rtmc_pkg::cipher_step(st[s], y, key);
      end
    end

    // Remaining input bits move along, consumed LSB first
    if (s < NI - 1) begin : g_din
      always_ff @(posedge clk) begin
        if (adv) begin
          din[s+1] <= din[s] >> 1;
        end
      end
    end

    // Output bits shift in from the top; first bit ends at bit 0
    if (s == OS) begin : g_mac_first
      always_ff @(posedge clk) begin
        if (adv) begin
          mac[s+1] <= {st[s].r[rtmc_pkg::OUT_BIT], 31'b0};
        end
      end
    end else if (s > OS) begin : g_mac
      always_ff @(posedge clk) begin
        if (adv) begin
          mac[s+1] <= {st[s].r[rtmc_pkg::OUT_BIT], mac[s][31:1]};
        end
      end
    end
  end

  assign out_valid = vld[NS];
  assign tag_mac   = mac[NS];

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int LATENCY     = 161;
  localparam int HOLD_CYCLES = 600;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX  = 10;

  // cipher seeds and taps
  localparam bit [15:0] TOP_TAPS  = 16'hc533;
  localparam bit [15:0] TOP_SEED  = 16'he012;
  localparam bit [7:0]  BOT_SEED  = 8'h4c;
  localparam bit [7:0]  LEFT_ADD  = 8'hec;
  localparam bit [7:0]  RIGHT_ADD = 8'h21;
  localparam int        MAC_TAP   = 2;
  localparam int        CHAL_BITS = 64;
  localparam int        NONCE_END = 96;
  localparam int        MAC_START = 128;
  localparam int        ROUNDS    = 160;

  // key byte pick, indexed by the right byte
  localparam bit [2:0] KEY_SEL [256] = '{
    3'd0,3'd3,3'd2,3'd1,3'd2,3'd3,3'd0,3'd1,3'd4,3'd7,3'd7,3'd4,3'd6,3'd7,3'd5,3'd4,
    3'd1,3'd2,3'd3,3'd0,3'd2,3'd3,3'd0,3'd1,3'd5,3'd6,3'd6,3'd5,3'd6,3'd7,3'd5,3'd4,
    3'd6,3'd5,3'd4,3'd7,3'd4,3'd5,3'd6,3'd7,3'd6,3'd5,3'd5,3'd6,3'd4,3'd5,3'd7,3'd6,
    3'd7,3'd4,3'd5,3'd6,3'd4,3'd5,3'd6,3'd7,3'd7,3'd4,3'd4,3'd7,3'd4,3'd5,3'd7,3'd6,
    3'd6,3'd5,3'd4,3'd7,3'd4,3'd5,3'd6,3'd7,3'd2,3'd1,3'd1,3'd2,3'd0,3'd1,3'd3,3'd2,
    3'd3,3'd0,3'd1,3'd2,3'd0,3'd1,3'd2,3'd3,3'd7,3'd4,3'd4,3'd7,3'd4,3'd5,3'd7,3'd6,
    3'd0,3'd3,3'd2,3'd1,3'd2,3'd3,3'd0,3'd1,3'd0,3'd3,3'd3,3'd0,3'd2,3'd3,3'd1,3'd0,
    3'd5,3'd6,3'd7,3'd4,3'd6,3'd7,3'd4,3'd5,3'd5,3'd6,3'd6,3'd5,3'd6,3'd7,3'd5,3'd4,
    3'd2,3'd1,3'd0,3'd3,3'd0,3'd1,3'd2,3'd3,3'd6,3'd5,3'd5,3'd6,3'd4,3'd5,3'd7,3'd6,
    3'd3,3'd0,3'd1,3'd2,3'd0,3'd1,3'd2,3'd3,3'd7,3'd4,3'd4,3'd7,3'd4,3'd5,3'd7,3'd6,
    3'd2,3'd1,3'd0,3'd3,3'd0,3'd1,3'd2,3'd3,3'd2,3'd1,3'd1,3'd2,3'd0,3'd1,3'd3,3'd2,
    3'd3,3'd0,3'd1,3'd2,3'd0,3'd1,3'd2,3'd3,3'd3,3'd0,3'd0,3'd3,3'd0,3'd1,3'd3,3'd2,
    3'd4,3'd7,3'd6,3'd5,3'd6,3'd7,3'd4,3'd5,3'd0,3'd3,3'd3,3'd0,3'd2,3'd3,3'd1,3'd0,
    3'd1,3'd2,3'd3,3'd0,3'd2,3'd3,3'd0,3'd1,3'd5,3'd6,3'd6,3'd5,3'd6,3'd7,3'd5,3'd4,
    3'd4,3'd7,3'd6,3'd5,3'd6,3'd7,3'd4,3'd5,3'd4,3'd7,3'd7,3'd4,3'd6,3'd7,3'd5,3'd4,
    3'd1,3'd2,3'd3,3'd0,3'd2,3'd3,3'd0,3'd1,3'd1,3'd2,3'd2,3'd1,3'd2,3'd3,3'd1,3'd0
  };

  typedef struct {
    bit [63:0] chal;
    bit [31:0] nonce;
  } auth_req_t;

  logic        clk             = 1'b0;
  logic        rst             = 1'b1;
  logic        cfg_we          = 1'b0;
  logic [63:0] diversified_key = '0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [63:0] card_challenge  = '0;
  logic [31:0] reader_nonce    = '0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [31:0] tag_mac;

  bit [63:0]   key_shadow      = '0;
  int          send_idle_pct   = 0;
  int          recv_stall_pct  = 0;
  logic        hold_kick       = 1'b0;
  int          hold_left       = 0;
  int          mismatches      = 0;
  int          cycles          = 0;

  auth_req_t   auth_reqs[$];
  bit [31:0]   tag_mac_due[$];

  rfid_tag_mac_cipher DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .diversified_key (diversified_key),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .card_challenge  (card_challenge),
    .reader_nonce    (reader_nonce),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .tag_mac         (tag_mac)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // MAC over 160 rounds: challenge, nonce, blank mixing, then output rounds
  function automatic bit [31:0] calc_tag_mac(bit [63:0] key, bit [63:0] chal,
                                             bit [31:0] nonce);
    bit [7:0]  seed;
    bit [7:0]  left_b;
    bit [7:0]  right_b;
    bit [7:0]  bot_b;
    bit [7:0]  prev_r;
    bit [7:0]  sum_r;
    bit [15:0] top_r;
    bit        par;
    bit        din;
    bit        fb_top;
    bit        fb_bot;
    bit [2:0]  lut;
    bit [2:0]  pick;
    bit [31:0] mac;
    int        n;
    seed    = key[7:0] ^ BOT_SEED;
    left_b  = seed + LEFT_ADD;
    right_b = seed + RIGHT_ADD;
    bot_b   = BOT_SEED;
    top_r   = TOP_SEED;
    mac     = '0;
    for (n = 0; n < ROUNDS; n++) begin
      if (n < CHAL_BITS)
        din = chal[n];
      else if (n < NONCE_END)
        din = nonce[n - CHAL_BITS];
      else
        din = 1'b0;
      if (n >= MAC_START)
        mac[n - MAC_START] = right_b[MAC_TAP];
      // the shift cascade on the tapped top bits folds down to their parity
      par     = ^(top_r & TOP_TAPS);
      prev_r  = right_b;
      fb_top  = par ^ prev_r[7] ^ prev_r[3];
      top_r   = {fb_top, top_r[15:1]};
      fb_bot  = bot_b[0] ^ bot_b[6] ^ bot_b[5] ^ bot_b[4] ^ prev_r[0];
      bot_b   = {fb_bot, bot_b[7:1]};
      lut     = KEY_SEL[prev_r];
      pick    = {lut[2], lut[1] ^ par ^ din, lut[0] ^ par};
      sum_r   = (key[8 * int'(pick) +: 8] ^ bot_b) + left_b;
      right_b = sum_r;
      left_b  = sum_r + prev_r;
    end
    return mac;
  endfunction

  function automatic auth_req_t rand_req();
    auth_req_t q;
    q.chal  = {$urandom, $urandom};
    q.nonce = $urandom;
    // now and then pin a field to an extreme
    case ($urandom_range(7))
      0: q.chal = '0;
      1: q.chal = '1;
      2: q.nonce = '0;
      3: q.nonce = '1;
      default: ;
    endcase
    return q;
  endfunction

  task automatic add_req(input bit [63:0] c, input bit [31:0] n);
    auth_req_t q;
    q.chal  = c;
    q.nonce = n;
    auth_reqs.push_back(q);
  endtask

  task automatic push_directed();
    add_req('0, '0);
    add_req('1, '1);
    add_req('1, '0);
    add_req('0, '1);
    add_req(64'h1, '0);
    add_req(64'h8000_0000_0000_0000, '0);
    add_req('0, 32'h1);
    add_req('0, 32'h8000_0000);
    add_req(64'haaaa_aaaa_aaaa_aaaa, 32'h5555_5555);
    add_req(64'h5555_5555_5555_5555, 32'haaaa_aaaa);
    add_req(64'h0123_4567_89ab_cdef, 32'hdead_beef);
    add_req(64'hfedc_ba98_7654_3210, 32'h0f0f_f0f0);
  endtask

  task automatic push_random(input int count);
    int i;
    for (i = 0; i < count; i++)
      auth_reqs.push_back(rand_req());
  endtask

  // wait until every queued word has gone in and its MAC has come back;
  // sampled mid-cycle so the driver's updates at the edge have settled
  task automatic drain();
    while (auth_reqs.size() != 0 || in_valid || tag_mac_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_key(input bit [63:0] k);
    @(posedge clk);
    cfg_we          <= 1'b1;
    diversified_key <= k;
    key_shadow      <= k;
    @(posedge clk);
    cfg_we          <= 1'b0;
  endtask

  task automatic set_pace(input int idle_pct, input int stall_pct);
    send_idle_pct  <= idle_pct;
    recv_stall_pct <= stall_pct;
  endtask

  // stimulus sequencing
  initial begin
    int p;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed words under the reset key, then under the all-ones key
    push_directed();
    drain();
    write_key('1);
    push_directed();
    drain();

    // random phases, cycling through the pacing modes
    for (p = 0; p < 7; p++) begin
      write_key(p == 3 ? 64'h0 : {$urandom, $urandom});
      case (p % 4)
        0: set_pace(0, 0);
        1: set_pace(75, 0);
        2: set_pace(0, 75);
        default: set_pace(35, 35);
      endcase
      push_random(125);
      drain();
    end

    // back-pressure: receiver holds off long enough to fill the pipe
    write_key({$urandom, $urandom});
    set_pace(0, 0);
    @(posedge clk);
    hold_kick <= 1'b1;
    @(posedge clk);
    hold_kick <= 1'b0;
    push_random(250);
    drain();

    repeat (LATENCY + 40) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // input driver
  always @(posedge clk) begin : req_drive
    auth_req_t q;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        tag_mac_due.push_back(calc_tag_mac(key_shadow, card_challenge, reader_nonce));
      // a stalled word holds; otherwise load the next one or go idle
      if (!in_valid || !in_stall) begin
        if (auth_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          q = auth_reqs.pop_front();
          in_valid       <= 1'b1;
          card_challenge <= q.chal;
          reader_nonce   <= q.nonce;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off counter
  always @(posedge clk) begin
    if (rst)
      hold_left <= 0;
    else if (hold_kick)
      hold_left <= HOLD_CYCLES;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  // output monitor and checker
  always @(posedge clk) begin : mac_check
    bit [31:0] want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tag_mac_due.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("unexpected tag_mac word %h", tag_mac);
          mismatches <= mismatches + 1;
        end else begin
          want = tag_mac_due.pop_front();
          if (tag_mac !== want) begin
            if (mismatches < REPORT_MAX)
              $display("tag_mac mismatch: expected %h, got %h", want, tag_mac);
            mismatches <= mismatches + 1;
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

/* rfid_tag_mac_cipher.f */
design/rtmc_pkg.sv
design/rfid_tag_mac_cipher.sv
tb/tb_top.sv
